### rtl/core/rk4ep_pkg.sv
// Shared widths, codes and controller/datapath types of the RK4 epidemic stepper.
package rk4ep_pkg;

  // Field widths.
  localparam int unsigned POP_W     = 32;  // signed Q2.30 populations
  localparam int unsigned RATE_W    = 16;  // unsigned Q0.16 rates and step size
  localparam int unsigned TIME_W    = 32;  // unsigned Q16.16 elapsed time
  localparam int unsigned CFG_IDX_W = 2;

  // Fraction bits.
  localparam int unsigned FRAC_POP  = 30;
  localparam int unsigned FRAC_RATE = 16;

  // Internal widths.
  localparam int unsigned PROD_W   = 64;  // registered product
  localparam int unsigned DER_W    = 34;  // p, bsi, gi, bsi-gi, ds, di
  localparam int unsigned ACC_W    = 37;  // dx1 + 2dx2 + 2dx3 + dx4
  localparam int unsigned DIV_W    = 40;  // |acc| + 3, then quotient
  localparam int unsigned DIV_BITS = 8;   // quotient bits per cycle
  localparam int unsigned DIV_CYC  = DIV_W / DIV_BITS;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_CYC);

  // Opcodes.
  localparam logic OPC_STEP = 1'b0;
  localparam logic OPC_LOAD = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_INFECTION_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_RATE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE      = 2'd2;

  // Configuration reset values.
  localparam logic [RATE_W-1:0] INFECTION_RATE_RST = 16'd0;
  localparam logic [RATE_W-1:0] RECOVERY_RATE_RST  = 16'd5243;
  localparam logic [RATE_W-1:0] STEP_SIZE_RST      = 16'd655;

  // RK stage numbering.
  localparam logic [1:0] STAGE_FIRST = 2'd0;
  localparam logic [1:0] STAGE_FULL  = 2'd2;  // third stage: next argument takes full dx
  localparam logic [1:0] STAGE_LAST  = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_SI,
    ST_MUL_GI,
    ST_MUL_BP,
    ST_RND_B,
    ST_MUL_BD,
    ST_MUL_DD,
    ST_RND_D,
    ST_UPD,
    ST_DIV_PREP,
    ST_DIV,
    ST_FIN,
    ST_PUSH
  } ctl_state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_START,
    OP_MUL_SI,
    OP_MUL_GI,
    OP_MUL_BP,
    OP_RND_B,
    OP_MUL_BD,
    OP_MUL_DD,
    OP_RND_D,
    OP_UPD,
    OP_DIV_PREP,
    OP_DIV,
    OP_FIN,
    OP_PUSH
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] stage;
  } cmd_t;

endpackage

### rtl/core/rk4ep_in_if.sv
// Input item channel: opcode and load populations.
interface rk4ep_in_if;
  import rk4ep_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    opcode;
  logic signed [POP_W-1:0] load_susceptible;
  logic signed [POP_W-1:0] load_infected;

  modport source (output valid, output opcode, output load_susceptible,
                  output load_infected, input ready);
  modport sink   (input valid, input opcode, input load_susceptible,
                  input load_infected, output ready);
endinterface

### rtl/core/rk4ep_out_if.sv
// Result channel: populations and elapsed time.
interface rk4ep_out_if;
  import rk4ep_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [POP_W-1:0] susceptible;
  logic signed [POP_W-1:0] infected;
  logic [TIME_W-1:0]       elapsed_time;

  modport source (output valid, output susceptible, output infected,
                  output elapsed_time, input ready);
  modport sink   (input valid, input susceptible, input infected,
                  input elapsed_time, output ready);
endinterface

### rtl/core/rk4ep_cfg_if.sv
// Configuration write channel: register index and write data.
interface rk4ep_cfg_if;
  import rk4ep_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [RATE_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/rk4_two_population_epidemic_step.sv
// Step item: four RK stages, the divide loop, the final update, then the result push.
// Each stage issues five products in series on the one shared multiplier;
// the divide by six of the weighted sum yields 8 quotient bits per cycle.
// Load item: loaded, then pushed. One item at a time; a push waits on out ready.
// Reset: populations and time clear to zero, rates take their defaults, no result pending.
module rk4_two_population_epidemic_step (
  input  logic        clk_i,
  input  logic        rst_ni,
  rk4ep_in_if.sink    in_i,
  rk4ep_out_if.source out_o,
  rk4ep_cfg_if.sink   cfg_i
);
  import rk4ep_pkg::*;

  cmd_t cmd;
  logic in_ready;
  logic out_valid;
  logic cfg_we;

  // Writes always taken, not checked: software must write only while the block is idle.
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid && cfg_i.ready;

  // Controller: takes an item only in its idle state; a step walks the four stages,
  // the divide loop and the final update, and each item is handed to the output register.
  rk4ep_ctl u_ctl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_opcode_i (in_i.opcode),
    .out_ready_i (out_o.ready),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .cmd_o       (cmd)
  );

  // Datapath: holds s, i, t, the rate registers and the result register; the result
  // register lets the next item transfer in while a finished result still waits.
  rk4ep_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .cfg_we_i           (cfg_we),
    .cfg_index_i        (cfg_i.index),
    .cfg_data_i         (cfg_i.data),
    .load_susceptible_i (in_i.load_susceptible),
    .load_infected_i    (in_i.load_infected),
    .susceptible_o      (out_o.susceptible),
    .infected_o         (out_o.infected),
    .elapsed_time_o     (out_o.elapsed_time)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

`ifndef SYNTH
  // after a transfer in, hold off the next one until the item completes
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input taken twice in a row");

  // never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |-> (cmd.op != OP_PUSH))
    else $error("result register overwritten while pending");

  // a new result appears only through the push command
  a_push_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(cmd.op == OP_PUSH))
    else $error("result valid without a push");

  // the update command of a non-final stage advances the stage counter by one
  a_stage_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == OP_UPD && cmd.stage != STAGE_LAST) |=>
      (cmd.stage == $past(cmd.stage) + 2'd1))
    else $error("stage counter out of sequence");
`endif

endmodule

### rtl/core/rk4ep_ctl.sv
// Sequencer of the RK4 step: stage loop, divide loop and result hand-off.
module rk4ep_ctl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_opcode_i,
  input  logic            out_ready_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  output rk4ep_pkg::cmd_t cmd_o
);
  import rk4ep_pkg::*;

  ctl_state_e             state_q, state_d;
  logic [1:0]             stage_q, stage_d;
  logic [DIV_CNT_W-1:0]   div_cnt_q, div_cnt_d;
  logic                   out_valid_q, out_valid_d;
  logic                   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      stage_q     <= STAGE_FIRST;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stage_q     <= stage_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    stage_d     = stage_q;
    div_cnt_d   = div_cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.op    = OP_NONE;
    cmd_o.stage = stage_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          stage_d = STAGE_FIRST;
          if (in_opcode_i == OPC_LOAD) begin
            cmd_o.op = OP_LOAD;
            state_d  = ST_PUSH;
          end else begin
            cmd_o.op = OP_START;
            state_d  = ST_MUL_SI;
          end
        end
      end
      ST_MUL_SI: begin
        cmd_o.op = OP_MUL_SI;
        state_d  = ST_MUL_GI;
      end
      ST_MUL_GI: begin
        cmd_o.op = OP_MUL_GI;
        state_d  = ST_MUL_BP;
      end
      ST_MUL_BP: begin
        cmd_o.op = OP_MUL_BP;
        state_d  = ST_RND_B;
      end
      ST_RND_B: begin
        cmd_o.op = OP_RND_B;
        state_d  = ST_MUL_BD;
      end
      ST_MUL_BD: begin
        cmd_o.op = OP_MUL_BD;
        state_d  = ST_MUL_DD;
      end
      ST_MUL_DD: begin
        cmd_o.op = OP_MUL_DD;
        state_d  = ST_RND_D;
      end
      ST_RND_D: begin
        cmd_o.op = OP_RND_D;
        state_d  = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.op = OP_UPD;
        if (stage_q == STAGE_LAST) begin
          state_d = ST_DIV_PREP;
        end else begin
          stage_d = stage_q + 2'd1;
          state_d = ST_MUL_SI;
        end
      end
      ST_DIV_PREP: begin
        cmd_o.op  = OP_DIV_PREP;
        div_cnt_d = '0;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.op  = OP_DIV;
        div_cnt_d = div_cnt_q + 1'b1;
        if (div_cnt_q == DIV_CNT_W'(DIV_CYC - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.op = OP_FIN;
        state_d  = ST_PUSH;
      end
      ST_PUSH: begin
        // wait for the result register to drain
        if (out_free) begin
          cmd_o.op    = OP_PUSH;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/rk4ep_dp.sv
// Datapath: shared multiplier, rounding, stage accumulation and divide by six.
module rk4ep_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  rk4ep_pkg::cmd_t                        cmd_i,
  input  logic                                   cfg_we_i,
  input  logic [rk4ep_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [rk4ep_pkg::RATE_W-1:0]           cfg_data_i,
  input  logic signed [rk4ep_pkg::POP_W-1:0]     load_susceptible_i,
  input  logic signed [rk4ep_pkg::POP_W-1:0]     load_infected_i,
  output logic signed [rk4ep_pkg::POP_W-1:0]     susceptible_o,
  output logic signed [rk4ep_pkg::POP_W-1:0]     infected_o,
  output logic [rk4ep_pkg::TIME_W-1:0]           elapsed_time_o
);
  import rk4ep_pkg::*;

  localparam logic [3:0] DIVISOR = 4'd6;

  typedef struct packed {
    logic [DIV_W-1:0] mag;
    logic [2:0]       rem;
  } div_t;

  // Round to nearest, ties away from zero, then shift right by n.
  function automatic logic signed [PROD_W-1:0] rnd_shift(
    input logic signed [PROD_W-1:0] v,
    input int unsigned              n
  );
    logic signed [PROD_W-1:0] half;
    logic signed [PROD_W-1:0] sum;
    half = PROD_W'(64'sd1 <<< (n - 1));
    sum  = v + half - $signed({{(PROD_W-1){1'b0}}, v[PROD_W-1]});
    return sum >>> n;
  endfunction

  function automatic logic signed [POP_W-1:0] sat_pop(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = PROD_W'({1'b0, {(POP_W-1){1'b1}}});
    lo = -hi - PROD_W'(1);
    if (v > hi) begin
      return {1'b0, {(POP_W-1){1'b1}}};
    end else if (v < lo) begin
      return {1'b1, {(POP_W-1){1'b0}}};
    end
    return v[POP_W-1:0];
  endfunction

  // Restoring divide by six, DIV_BITS quotient bits per call.
  function automatic div_t div6_step(input div_t x);
    div_t       r;
    logic [3:0] r4;
    r = x;
    for (int k = 0; k < DIV_BITS; k++) begin
      r4    = {r.rem, r.mag[DIV_W-1]};
      r.mag = r.mag << 1;
      if (r4 >= DIVISOR) begin
        r.rem    = 3'(r4 - DIVISOR);
        r.mag[0] = 1'b1;
      end else begin
        r.rem = r4[2:0];
      end
    end
    return r;
  endfunction

  // configuration and integrator state
  logic [RATE_W-1:0]        beta_q, gamma_q, dt_q;
  logic signed [POP_W-1:0]  s_q, s_d, i_q, i_d;
  logic [TIME_W-1:0]        t_q, t_d;

  // working registers
  logic signed [POP_W-1:0]  s_arg_q, s_arg_d, i_arg_q, i_arg_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [DER_W-1:0]  p_q, p_d, gi_q, gi_d, bsi_q, bsi_d, diff_q, diff_d;
  logic signed [DER_W-1:0]  ds_q, ds_d, di_q, di_d;
  logic signed [ACC_W-1:0]  acc_s_q, acc_s_d, acc_i_q, acc_i_d;
  div_t                     div_s_q, div_s_d, div_i_q, div_i_d;
  logic                     neg_s_q, neg_s_d, neg_i_q, neg_i_d;
  logic signed [POP_W-1:0]  res_s_q, res_s_d, res_i_q, res_i_d;
  logic [TIME_W-1:0]        res_t_q, res_t_d;

  // shared multiplier
  logic signed [DER_W-1:0]       mul_a;
  logic signed [POP_W-1:0]       mul_b;
  logic signed [DER_W+POP_W-1:0] mul_p;

  logic signed [POP_W-1:0]  dt_s, beta_s, gamma_s;
  logic signed [ACC_W-1:0]  term_s, term_i, abs_s, abs_i;
  logic signed [PROD_W-1:0] step_s, step_i;
  logic signed [DIV_W-1:0]  q_s, q_i;
  logic [TIME_W:0]          t_sum;
  logic                     full_weight;

  assign dt_s    = $signed({{(POP_W-RATE_W){1'b0}}, dt_q});
  assign beta_s  = $signed({{(POP_W-RATE_W){1'b0}}, beta_q});
  assign gamma_s = $signed({{(POP_W-RATE_W){1'b0}}, gamma_q});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      OP_MUL_SI: begin
        mul_a = DER_W'(s_arg_q);
        mul_b = i_arg_q;
      end
      OP_MUL_GI: begin
        mul_a = DER_W'(i_arg_q);
        mul_b = gamma_s;
      end
      OP_MUL_BP: begin
        mul_a = p_q;
        mul_b = beta_s;
      end
      OP_MUL_BD: begin
        mul_a = bsi_q;
        mul_b = dt_s;
      end
      OP_MUL_DD: begin
        mul_a = diff_q;
        mul_b = dt_s;
      end
      default: begin
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // stage weights 1, 2, 2, 1
  assign full_weight = (cmd_i.stage == STAGE_FIRST) || (cmd_i.stage == STAGE_LAST);
  assign term_s = full_weight ? ACC_W'(ds_q) : (ACC_W'(ds_q) <<< 1);
  assign term_i = full_weight ? ACC_W'(di_q) : (ACC_W'(di_q) <<< 1);

  // next stage argument offset: half of dx for stages two and three, full dx for four
  assign step_s = (cmd_i.stage == STAGE_FULL) ? PROD_W'(ds_q) : rnd_shift(PROD_W'(ds_q), 1);
  assign step_i = (cmd_i.stage == STAGE_FULL) ? PROD_W'(di_q) : rnd_shift(PROD_W'(di_q), 1);

  assign abs_s = acc_s_q[ACC_W-1] ? -acc_s_q : acc_s_q;
  assign abs_i = acc_i_q[ACC_W-1] ? -acc_i_q : acc_i_q;

  assign q_s = neg_s_q ? -$signed(div_s_q.mag) : $signed(div_s_q.mag);
  assign q_i = neg_i_q ? -$signed(div_i_q.mag) : $signed(div_i_q.mag);

  assign t_sum = (TIME_W+1)'(t_q) + (TIME_W+1)'(dt_q);

  always_comb begin
    s_d     = s_q;
    i_d     = i_q;
    t_d     = t_q;
    s_arg_d = s_arg_q;
    i_arg_d = i_arg_q;
    prod_d  = prod_q;
    p_d     = p_q;
    gi_d    = gi_q;
    bsi_d   = bsi_q;
    diff_d  = diff_q;
    ds_d    = ds_q;
    di_d    = di_q;
    acc_s_d = acc_s_q;
    acc_i_d = acc_i_q;
    div_s_d = div_s_q;
    div_i_d = div_i_q;
    neg_s_d = neg_s_q;
    neg_i_d = neg_i_q;
    res_s_d = res_s_q;
    res_i_d = res_i_q;
    res_t_d = res_t_q;
    unique case (cmd_i.op)
      OP_LOAD: begin
        s_d = load_susceptible_i;
        i_d = load_infected_i;
        t_d = '0;
      end
      OP_START: begin
        s_arg_d = s_q;
        i_arg_d = i_q;
      end
      OP_MUL_SI: begin
        prod_d = $signed(mul_p[PROD_W-1:0]);
      end
      OP_MUL_GI: begin
        p_d    = DER_W'(rnd_shift(prod_q, FRAC_POP));
        prod_d = $signed(mul_p[PROD_W-1:0]);
      end
      OP_MUL_BP: begin
        gi_d   = DER_W'(rnd_shift(prod_q, FRAC_RATE));
        prod_d = $signed(mul_p[PROD_W-1:0]);
      end
      OP_RND_B: begin
        bsi_d = DER_W'(rnd_shift(prod_q, FRAC_RATE));
      end
      OP_MUL_BD: begin
        prod_d = $signed(mul_p[PROD_W-1:0]);
        diff_d = bsi_q - gi_q;
      end
      OP_MUL_DD: begin
        ds_d   = -DER_W'(rnd_shift(prod_q, FRAC_RATE));
        prod_d = $signed(mul_p[PROD_W-1:0]);
      end
      OP_RND_D: begin
        di_d = DER_W'(rnd_shift(prod_q, FRAC_RATE));
      end
      OP_UPD: begin
        acc_s_d = ((cmd_i.stage == STAGE_FIRST) ? '0 : acc_s_q) + term_s;
        acc_i_d = ((cmd_i.stage == STAGE_FIRST) ? '0 : acc_i_q) + term_i;
        s_arg_d = sat_pop(PROD_W'(s_q) + step_s);
        i_arg_d = sat_pop(PROD_W'(i_q) + step_i);
      end
      OP_DIV_PREP: begin
        neg_s_d     = acc_s_q[ACC_W-1];
        neg_i_d     = acc_i_q[ACC_W-1];
        div_s_d.mag = DIV_W'(abs_s) + DIV_W'(3);
        div_i_d.mag = DIV_W'(abs_i) + DIV_W'(3);
        div_s_d.rem = '0;
        div_i_d.rem = '0;
      end
      OP_DIV: begin
        div_s_d = div6_step(div_s_q);
        div_i_d = div6_step(div_i_q);
      end
      OP_FIN: begin
        s_d = sat_pop(PROD_W'(s_q) + PROD_W'(q_s));
        i_d = sat_pop(PROD_W'(i_q) + PROD_W'(q_i));
        t_d = t_sum[TIME_W] ? '1 : t_sum[TIME_W-1:0];
      end
      OP_PUSH: begin
        res_s_d = s_q;
        res_i_d = i_q;
        res_t_d = t_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beta_q  <= INFECTION_RATE_RST;
      gamma_q <= RECOVERY_RATE_RST;
      dt_q    <= STEP_SIZE_RST;
      s_q     <= '0;
      i_q     <= '0;
      t_q     <= '0;
    end else begin
      // drop writes to indexes beyond the register list
      if (cfg_we_i && (cfg_index_i == CFG_INFECTION_RATE)) begin
        beta_q <= cfg_data_i;
      end
      if (cfg_we_i && (cfg_index_i == CFG_RECOVERY_RATE)) begin
        gamma_q <= cfg_data_i;
      end
      if (cfg_we_i && (cfg_index_i == CFG_STEP_SIZE)) begin
        dt_q <= cfg_data_i;
      end
      s_q <= s_d;
      i_q <= i_d;
      t_q <= t_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_arg_q <= s_arg_d;
    i_arg_q <= i_arg_d;
    prod_q  <= prod_d;
    p_q     <= p_d;
    gi_q    <= gi_d;
    bsi_q   <= bsi_d;
    diff_q  <= diff_d;
    ds_q    <= ds_d;
    di_q    <= di_d;
    acc_s_q <= acc_s_d;
    acc_i_q <= acc_i_d;
    div_s_q <= div_s_d;
    div_i_q <= div_i_d;
    neg_s_q <= neg_s_d;
    neg_i_q <= neg_i_d;
    res_s_q <= res_s_d;
    res_i_q <= res_i_d;
    res_t_q <= res_t_d;
  end

  assign susceptible_o  = res_s_q;
  assign infected_o     = res_i_q;
  assign elapsed_time_o = res_t_q;

endmodule
